// ===== src/ucfp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, command codes and helpers of the serial command frame parser.
// No dependencies; every other file of the block refers to it by scoped names.
package ucfp_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned SensorW = 16;

  localparam logic [ByteW-1:0] CMD_HORIZON_ON  = 8'h1F;
  localparam logic [ByteW-1:0] CMD_HORIZON_OFF = 8'h1E;
  localparam logic [ByteW-1:0] CMD_BARO_ON     = 8'h29;
  localparam logic [ByteW-1:0] CMD_BARO_OFF    = 8'h28;
  localparam logic [ByteW-1:0] CMD_MAG_ON      = 8'h33;
  localparam logic [ByteW-1:0] CMD_MAG_OFF     = 8'h32;
  localparam logic [ByteW-1:0] CMD_FRAME_OPEN  = 8'h5A;

  localparam logic [SensorW-1:0] SENSOR_RESET = 16'd200;

  // Checksum modulus and its scaled reciprocal: floor(x * 205 / 2048) equals
  // floor(x / 10) for every x below 1029, which covers a 9-bit byte sum.
  localparam int unsigned CheckModulus = 10;
  localparam int unsigned RecipMul     = 205;
  localparam int unsigned RecipShift   = 11;
  localparam int unsigned SumW         = ByteW + 1;
  localparam int unsigned ProdW        = SumW + 8;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_HIGH  = 4'b0010,
    PH_LOW   = 4'b0100,
    PH_CHECK = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [ByteW-1:0]   reply_code;
    logic               horizon_mode;
    logic               baro_mode;
    logic               mag_mode;
    logic [SensorW-1:0] sensor_value;
    logic               frame_done;
    logic               frame_accepted;
  } result_t;

  // Sum of two bytes modulo ten, without a divider.
  function automatic logic [3:0] sum_mod10(input logic [ByteW-1:0] a,
                                           input logic [ByteW-1:0] b);
    logic [SumW-1:0]  sum;
    logic [ProdW-1:0] prod;
    logic [SumW-1:0]  quot;
    logic [SumW-1:0]  rem;
    sum  = {1'b0, a} + {1'b0, b};
    prod = {8'd0, sum} * ProdW'(RecipMul);
    quot = SumW'(prod >> RecipShift);
    rem  = sum - SumW'(quot * SumW'(CheckModulus));
    return rem[3:0];
  endfunction

endpackage

// ===== src/ucfp_rx_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel that carries one received serial byte per word.
// Depends on ucfp_pkg for the byte width.
interface ucfp_rx_if;
  logic                      valid;
  logic                      ready;
  logic [ucfp_pkg::ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== src/ucfp_reply_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel that carries one parser result word.
// Depends on ucfp_pkg for field widths.
interface ucfp_reply_if;
  logic                        valid;
  logic                        ready;
  logic [ucfp_pkg::ByteW-1:0]   reply_code;
  logic                        horizon_mode;
  logic                        baro_mode;
  logic                        mag_mode;
  logic [ucfp_pkg::SensorW-1:0] sensor_value;
  logic                        frame_done;
  logic                        frame_accepted;

  modport source (output valid, output reply_code, output horizon_mode, output baro_mode,
                  output mag_mode, output sensor_value, output frame_done,
                  output frame_accepted, input ready);
  modport sink (input valid, input reply_code, input horizon_mode, input baro_mode,
                input mag_mode, input sensor_value, input frame_done,
                input frame_accepted, output ready);
endinterface

// ===== src/ucfp_in_stage.sv =====
`timescale 1ns / 1ps
// Input register of the parser: captures one received byte per word.
// Depends on ucfp_pkg and ucfp_rx_if.
module ucfp_in_stage (
  input  logic                       clk,
  input  logic                       rst,
  ucfp_rx_if.sink                    rx,
  input  logic                       advance,
  output logic                       valid,
  output logic [ucfp_pkg::ByteW-1:0] rx_byte
);

  // Take a new word when empty or when the held word moves on this cycle.
  assign rx.ready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (rx.ready) begin
      valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      rx_byte <= rx.rx_byte;
    end
  end

endmodule

// ===== src/ucfp_decode.sv =====
`timescale 1ns / 1ps
// Parser state and decode: frame phase, captured data bytes, mode flags and
// sensor word, plus the result for the byte being committed. Depends on ucfp_pkg.
module ucfp_decode (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       commit,
  input  logic [ucfp_pkg::ByteW-1:0] rx_byte,
  output ucfp_pkg::result_t          res
);

  ucfp_pkg::phase_t                 phase, phase_next;
  logic [ucfp_pkg::ByteW-1:0]       high_byte, high_byte_next;
  logic [ucfp_pkg::ByteW-1:0]       low_byte, low_byte_next;
  logic                             horizon_flag, horizon_flag_next;
  logic                             baro_flag, baro_flag_next;
  logic                             mag_flag, mag_flag_next;
  logic [ucfp_pkg::SensorW-1:0]     sensor_word, sensor_word_next;
  logic [3:0]                       check_sum;
  logic                             check_ok;
  logic [ucfp_pkg::ByteW-1:0]       reply;

  assign check_sum = ucfp_pkg::sum_mod10(high_byte, low_byte);
  assign check_ok  = (rx_byte == {4'd0, check_sum}) &&
                     ((high_byte != '0) || (low_byte != '0));

  always_comb begin
    phase_next        = phase;
    high_byte_next    = high_byte;
    low_byte_next     = low_byte;
    horizon_flag_next = horizon_flag;
    baro_flag_next    = baro_flag;
    mag_flag_next     = mag_flag;
    sensor_word_next  = sensor_word;
    reply             = '0;
    res.frame_done     = 1'b0;
    res.frame_accepted = 1'b0;
    case (phase)
      ucfp_pkg::PH_HIGH: begin
        high_byte_next = rx_byte;
        phase_next     = ucfp_pkg::PH_LOW;
      end
      ucfp_pkg::PH_LOW: begin
        low_byte_next = rx_byte;
        phase_next    = ucfp_pkg::PH_CHECK;
      end
      ucfp_pkg::PH_CHECK: begin
        res.frame_done = 1'b1;
        if (check_ok) begin
          res.frame_accepted = 1'b1;
          sensor_word_next   = {high_byte, low_byte};
        end
        phase_next = ucfp_pkg::PH_IDLE;
      end
      default: begin
        case (rx_byte)
          ucfp_pkg::CMD_HORIZON_ON: begin
            horizon_flag_next = 1'b1;
            reply             = rx_byte;
          end
          ucfp_pkg::CMD_HORIZON_OFF: begin
            horizon_flag_next = 1'b0;
            reply             = rx_byte;
          end
          ucfp_pkg::CMD_BARO_ON: begin
            baro_flag_next = 1'b1;
            reply          = rx_byte;
          end
          ucfp_pkg::CMD_BARO_OFF: begin
            baro_flag_next = 1'b0;
            reply          = rx_byte;
          end
          ucfp_pkg::CMD_MAG_ON: begin
            mag_flag_next = 1'b1;
            reply         = rx_byte;
          end
          ucfp_pkg::CMD_MAG_OFF: begin
            mag_flag_next = 1'b0;
            reply         = rx_byte;
          end
          ucfp_pkg::CMD_FRAME_OPEN: begin
            high_byte_next = '0;
            low_byte_next  = '0;
            phase_next     = ucfp_pkg::PH_HIGH;
          end
          default: begin
          end
        endcase
      end
    endcase
    res.reply_code   = reply;
    res.horizon_mode = horizon_flag_next;
    res.baro_mode    = baro_flag_next;
    res.mag_mode     = mag_flag_next;
    res.sensor_value = sensor_word_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= ucfp_pkg::PH_IDLE;
      high_byte    <= '0;
      low_byte     <= '0;
      horizon_flag <= 1'b0;
      baro_flag    <= 1'b0;
      mag_flag     <= 1'b0;
      sensor_word  <= ucfp_pkg::SENSOR_RESET;
    end else if (commit) begin
      phase        <= phase_next;
      high_byte    <= high_byte_next;
      low_byte     <= low_byte_next;
      horizon_flag <= horizon_flag_next;
      baro_flag    <= baro_flag_next;
      mag_flag     <= mag_flag_next;
      sensor_word  <= sensor_word_next;
    end
  end

`ifndef ASSERT_OFF
  a_accept_needs_done: assert property (@(posedge clk) disable iff (rst)
    res.frame_accepted |-> res.frame_done)
    else $error("frame accepted without closing byte");

  a_check_returns_idle: assert property (@(posedge clk) disable iff (rst)
    (commit && phase == ucfp_pkg::PH_CHECK) |=> phase == ucfp_pkg::PH_IDLE)
    else $error("phase did not return to idle after checksum byte");

  a_flags_hold_in_frame: assert property (@(posedge clk) disable iff (rst)
    (commit && phase != ucfp_pkg::PH_IDLE) |=>
      ($stable(horizon_flag) && $stable(baro_flag) && $stable(mag_flag)))
    else $error("mode flag changed by a frame byte");

  a_sensor_only_on_accept: assert property (@(posedge clk) disable iff (rst)
    (commit && !res.frame_accepted) |=> $stable(sensor_word))
    else $error("sensor word changed without an accepted frame");
`endif

endmodule

// ===== src/uart_command_frame_parser_core.sv =====
`timescale 1ns / 1ps
// Top level of the serial command frame parser: input register, decode with
// state, and result register. Depends on ucfp_pkg, both channel interfaces,
// ucfp_in_stage and ucfp_decode.
//
// Usage:
//   rx carries one received serial byte per word; reply returns exactly one
//   result word for every byte taken, in order. Idle bytes 0x1F/0x1E,
//   0x29/0x28 and 0x33/0x32 set/clear the horizon, barometer and magnetometer
//   flags and are echoed in reply_code. 0x5A opens a frame of high byte, low
//   byte and checksum; the closing word raises frame_done, and frame_accepted
//   when the checksum equals (high + low) mod 10 and the data is nonzero, in
//   which case sensor_value takes {high, low}.
//   Each byte passes the input register, then the result register. While
//   reply.ready is high, throughput is one byte per cycle; the path between the
//   two registers is a byte decode plus a 9-bit sum and constant-modulus remainder.
//   Reset (synchronous, rst high): both registers empty, flags cleared,
//   frame phase idle, internal sensor word 200 (sensor_value itself is not reset).
//   Stall: while reply.ready is low the result word holds; one further byte
//   is held in the input register, after which rx.ready drops.
module uart_command_frame_parser_core (
  input  logic          clk,
  input  logic          rst,
  ucfp_rx_if.sink       rx,
  ucfp_reply_if.source  reply
);

  logic                       in_valid;
  logic [ucfp_pkg::ByteW-1:0] in_byte;
  logic                       advance;
  logic                       out_valid;
  ucfp_pkg::result_t          dec_res;
  ucfp_pkg::result_t          out_res;

  // Move the held byte on when the result register is empty or being drained.
  assign advance = in_valid && (!out_valid || reply.ready);

  ucfp_in_stage u_in_stage (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx),
    .advance (advance),
    .valid   (in_valid),
    .rx_byte (in_byte)
  );

  // State updates only when the byte's result is written to the output.
  ucfp_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .commit  (advance),
    .rx_byte (in_byte),
    .res     (dec_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (reply.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Payload needs no reset; load with each committed byte.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= dec_res;
    end
  end

  assign reply.valid          = out_valid;
  assign reply.reply_code     = out_res.reply_code;
  assign reply.horizon_mode   = out_res.horizon_mode;
  assign reply.baro_mode      = out_res.baro_mode;
  assign reply.mag_mode       = out_res.mag_mode;
  assign reply.sensor_value   = out_res.sensor_value;
  assign reply.frame_done     = out_res.frame_done;
  assign reply.frame_accepted = out_res.frame_accepted;

endmodule
